[sv/fpba_pkg.sv]
// Package: shared types and constants for the fit-policy block allocator.
`timescale 1ns / 1ps
package fpba_pkg;
    localparam int MAX_BLOCKS_DEF = 32;
    localparam int ADDR_BITS_DEF  = 16;
    localparam int OWNER_BITS_DEF = 16;

    localparam logic [1:0] OP_ALLOC    = 2'd0;
    localparam logic [1:0] OP_FREE     = 2'd1;
    localparam logic [1:0] OP_COALESCE = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_NO_OWNER = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic REG_POLICY    = 1'b0;
    localparam logic REG_PARTITION = 1'b1;

    // Row-wide command from the sequencer to every cell.
    typedef enum logic [2:0] {
        C_HOLD,
        C_INIT,    // cell 0 takes the load value, others hold
        C_REMOVE,  // cells at/after sel take their right neighbor
        C_INSERT,  // cells after sel take left neighbor, cell at sel takes load
        C_SWAP,    // cells sel and sel+1 exchange
        C_WRITE    // cell at sel takes load
    } t_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic ins_here_first;  // insert position is the first cell past data
    } t_ctl;
endpackage

[sv/fit_policy_block_allocator_unit.sv]
// Top level: contiguous block allocator with first/best/worst fit policy.
// Allocate and free scan the tables one table cell per cycle and make one row
// shift per edit; coalesce is a bubble sort over the free row, then a merge pass.
// One request at a time; the result register holds until taken.
// Reset (synchronous, active low) and a partition write load one free entry
// covering the whole partition.
`timescale 1ns / 1ps
module fit_policy_block_allocator_unit
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] opcode, [17:2] owner_id, [34:18] request_size, rest zero
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [17:2] block_start, [33:18] block_end, [39:34] free_entries
    output logic [39:0] m_axis_tdata
);
    localparam int IDX_BITS = $clog2(MAX_BLOCKS);
    localparam int CNT_BITS = $clog2(MAX_BLOCKS + 1);
    localparam int SZ_BITS  = ADDR_BITS + 1;
    localparam logic [CNT_BITS-1:0] MAXC = CNT_BITS'(MAX_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE, S_ASCAN, S_AREM, S_AUSED, S_UINS, S_FREM_SCAN, S_FREM,
        S_FINS_SCAN, S_FINS, S_SORT, S_MERGE, S_MWR, S_OUT
    } t_state;

    t_state                r_st;
    logic [1:0]            r_pol;
    logic [SZ_BITS-1:0]    r_part;
    logic                  r_init;
    logic [CNT_BITS-1:0]   r_fc, r_uc;
    logic [CNT_BITS-1:0]   r_i, r_pass;
    logic                  r_swapped;
    logic [1:0]            r_op;
    logic [OWNER_BITS-1:0] r_own;
    logic [SZ_BITS-1:0]    r_req;
    logic [ADDR_BITS-1:0]  r_bs, r_be, r_rs, r_re;
    logic                  r_rem;
    logic [CNT_BITS-1:0]   r_w;
    logic [ADDR_BITS-1:0]  r_ms, r_me;
    logic [1:0]            r_status;
    logic                  r_ovalid;
    logic [39:0]           r_odata;

    t_ctl                  f_ctl, u_ctl;
    logic [IDX_BITS-1:0]   f_sel, u_sel, f_rd, u_rd;
    logic [ADDR_BITS-1:0]  f_ls, f_le, u_ls, u_le;
    logic [OWNER_BITS-1:0] u_lo;
    logic [ADDR_BITS-1:0]  f_rs, f_re, f_ns, f_ne, u_rs, u_re, u_ns, u_ne;
    logic [OWNER_BITS-1:0] f_ro, u_ro;

    fpba_row #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS),
               .OWNER_BITS(OWNER_BITS)) u_free (
        .i_clk(i_clk), .i_cmd(f_ctl.cmd), .i_sel(f_sel), .i_load_s(f_ls),
        .i_load_e(f_le), .i_load_o('0), .i_rd(f_rd), .o_rd_s(f_rs),
        .o_rd_e(f_re), .o_rd_o(f_ro), .o_nx_s(f_ns), .o_nx_e(f_ne)
    );
    fpba_row #(.MAX_BLOCKS(MAX_BLOCKS), .ADDR_BITS(ADDR_BITS),
               .OWNER_BITS(OWNER_BITS)) u_used (
        .i_clk(i_clk), .i_cmd(u_ctl.cmd), .i_sel(u_sel), .i_load_s(u_ls),
        .i_load_e(u_le), .i_load_o(u_lo), .i_rd(u_rd), .o_rd_s(u_rs),
        .o_rd_e(u_re), .o_rd_o(u_ro), .o_nx_s(u_ns), .o_nx_e(u_ne)
    );

    logic [IDX_BITS-1:0] w_ix;
    logic [SZ_BITS-1:0]  w_fsz, w_isz, w_psz;
    logic                w_iend;
    logic [ADDR_BITS-1:0] w_is, w_ie;
    logic [ADDR_BITS-1:0] w_aend;
    logic                w_touch;
    logic                w_out_go;

    assign w_ix   = r_i[IDX_BITS-1:0];
    assign f_rd   = w_ix;
    assign u_rd   = w_ix;
    assign w_fsz  = SZ_BITS'(f_re) - SZ_BITS'(f_rs) + SZ_BITS'(1);
    assign w_iend = (r_i >= r_fc);
    // Entry to insert in free row: remainder after allocate, or freed block.
    assign w_is   = r_rem ? r_rs : r_bs;
    assign w_ie   = r_rem ? r_re : r_be;
    assign w_isz  = SZ_BITS'(w_ie) - SZ_BITS'(w_is) + SZ_BITS'(1);
    assign w_psz  = r_part - SZ_BITS'(1);
    assign w_aend = ADDR_BITS'(SZ_BITS'(f_rs) + r_req - SZ_BITS'(1));
    // Held merge entry ends right before the entry under the read pointer.
    assign w_touch  = (SZ_BITS'(r_me) + SZ_BITS'(1)) == SZ_BITS'(f_rs);
    assign w_out_go = (r_st == S_OUT) && (!r_ovalid || m_axis_tready);

    always_comb begin
        f_ctl = '{cmd: C_HOLD, ins_here_first: 1'b0};
        u_ctl = '{cmd: C_HOLD, ins_here_first: 1'b0};
        f_sel = w_ix;
        u_sel = w_ix;
        f_ls  = w_is;
        f_le  = w_ie;
        u_ls  = r_bs;
        u_le  = r_be;
        u_lo  = r_own;
        if (r_init) begin
            f_ctl.cmd = C_INIT;
            f_ls      = '0;
            f_le      = w_psz[ADDR_BITS-1:0];
        end else begin
            case (r_st)
                S_AREM:  f_ctl.cmd = C_REMOVE;
                S_UINS:  u_ctl.cmd = C_INSERT;
                S_FREM:  u_ctl.cmd = C_REMOVE;
                S_FINS:  f_ctl.cmd = C_INSERT;
                S_SORT: begin
                    if (r_i + CNT_BITS'(1) < r_fc && f_rs > f_ns)
                        f_ctl.cmd = C_SWAP;
                end
                S_MERGE: begin
                    // Flush the held entry when the next one does not touch it.
                    if (r_i != '0 && r_i < r_fc && !w_touch) begin
                        f_ctl.cmd = C_WRITE;
                        f_sel     = r_w[IDX_BITS-1:0];
                        f_ls      = r_ms;
                        f_le      = r_me;
                    end
                end
                S_MWR: begin
                    f_ctl.cmd = C_WRITE;
                    f_sel     = r_w[IDX_BITS-1:0];
                    f_ls      = r_ms;
                    f_le      = r_me;
                end
                default: ;
            endcase
        end
    end

    logic w_fit;
    assign w_fit = (r_pol == POL_BEST)  ? (w_fsz > w_isz) :
                   (r_pol == POL_WORST) ? (w_fsz < w_isz) : 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_pol    <= POL_FIRST;
            r_part   <= SZ_BITS'(1) << ADDR_BITS;
            r_init   <= 1'b1;
            r_fc     <= CNT_BITS'(1);
            r_uc     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_init <= i_cfg_we && (i_cfg_index == REG_PARTITION);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_POLICY: r_pol <= i_cfg_wdata[1:0];
                    REG_PARTITION: begin
                        if (i_cfg_wdata == '0)
                            r_part <= SZ_BITS'(1);
                        else if (17'(i_cfg_wdata) > 17'((SZ_BITS'(1) << ADDR_BITS)))
                            r_part <= SZ_BITS'(1) << ADDR_BITS;
                        else
                            r_part <= SZ_BITS'(i_cfg_wdata);
                        r_fc   <= CNT_BITS'(1);
                        r_uc   <= '0;
                    end
                    default: ;
                endcase
            end
            if (w_out_go) r_ovalid <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_op     <= s_axis_tdata[1:0];
                        r_own    <= OWNER_BITS'(s_axis_tdata[17:2]);
                        r_req    <= SZ_BITS'(s_axis_tdata[34:18]);
                        r_bs     <= '0;
                        r_be     <= '0;
                        r_rem    <= 1'b0;
                        r_status <= ST_DONE;
                        r_i      <= '0;
                        r_pass   <= '0;
                        r_swapped <= 1'b0;
                        case (s_axis_tdata[1:0])
                            OP_ALLOC:    r_st <= S_ASCAN;
                            OP_FREE:     r_st <= S_FREM_SCAN;
                            OP_COALESCE: r_st <= S_SORT;
                            default:     r_st <= S_OUT;
                        endcase
                    end
                end
                S_ASCAN: begin
                    if (w_iend || r_req == '0) begin
                        r_status <= ST_NO_FIT;
                        r_st     <= S_OUT;
                    end else if (w_fsz >= r_req) begin
                        if (r_uc >= MAXC) begin
                            r_status <= ST_FULL;
                            r_st     <= S_OUT;
                        end else begin
                            r_bs  <= f_rs;
                            r_be  <= w_aend;
                            r_rs  <= w_aend + ADDR_BITS'(1);
                            r_re  <= f_re;
                            r_rem <= (w_aend < f_re);
                            r_st  <= S_AREM;
                        end
                    end else begin
                        r_i <= r_i + CNT_BITS'(1);
                    end
                end
                S_AREM: begin
                    r_fc <= r_fc - CNT_BITS'(1);
                    r_i  <= '0;
                    r_st <= S_AUSED;
                end
                S_AUSED: begin
                    // Find the first used entry whose start is not below the block.
                    if (r_i >= r_uc || !(u_rs < r_bs)) r_st <= S_UINS;
                    else r_i <= r_i + CNT_BITS'(1);
                end
                S_UINS: begin
                    r_uc <= r_uc + CNT_BITS'(1);
                    r_i  <= '0;
                    r_st <= r_rem ? S_FINS_SCAN : S_OUT;
                end
                S_FREM_SCAN: begin
                    if (r_i >= r_uc) begin
                        r_status <= ST_NO_OWNER;
                        r_st     <= S_OUT;
                    end else if (u_ro == r_own) begin
                        if (r_fc >= MAXC) begin
                            r_status <= ST_FULL;
                            r_st     <= S_OUT;
                        end else begin
                            r_bs <= u_rs;
                            r_be <= u_re;
                            r_st <= S_FREM;
                        end
                    end else begin
                        r_i <= r_i + CNT_BITS'(1);
                    end
                end
                S_FREM: begin
                    r_uc <= r_uc - CNT_BITS'(1);
                    r_i  <= (r_pol == POL_BEST || r_pol == POL_WORST) ? '0 : r_fc;
                    r_st <= S_FINS_SCAN;
                end
                S_FINS_SCAN: begin
                    if (r_pol != POL_BEST && r_pol != POL_WORST) begin
                        r_i  <= r_fc;
                        r_st <= S_FINS;
                    end else if (w_iend || w_fit) begin
                        r_st <= S_FINS;
                    end else begin
                        r_i <= r_i + CNT_BITS'(1);
                    end
                end
                S_FINS: begin
                    r_fc <= r_fc + CNT_BITS'(1);
                    r_st <= S_OUT;
                end
                S_SORT: begin
                    // Bubble pass over the free row; stop after a clean pass.
                    if (r_i + CNT_BITS'(1) >= r_fc) begin
                        r_i <= '0;
                        if (!r_swapped || r_pass >= r_fc) begin
                            r_w  <= '0;
                            r_st <= S_MERGE;
                        end else begin
                            r_pass    <= r_pass + CNT_BITS'(1);
                            r_swapped <= 1'b0;
                        end
                    end else begin
                        if (f_rs > f_ns) r_swapped <= 1'b1;
                        r_i <= r_i + CNT_BITS'(1);
                    end
                end
                S_MERGE: begin
                    // Cell r_w is held in r_ms/r_me and written back on change.
                    if (r_i == '0) begin
                        if (r_fc == '0) begin
                            r_st <= S_OUT;
                        end else begin
                            r_ms <= f_rs;
                            r_me <= f_re;
                            r_i  <= CNT_BITS'(1);
                        end
                    end else if (r_i >= r_fc) begin
                        r_st <= S_MWR;
                    end else if (w_touch) begin
                        r_me <= f_re;
                        r_i  <= r_i + CNT_BITS'(1);
                    end else begin
                        r_w  <= r_w + CNT_BITS'(1);
                        r_ms <= f_rs;
                        r_me <= f_re;
                        r_i  <= r_i + CNT_BITS'(1);
                    end
                end
                S_MWR: begin
                    r_fc <= r_w + CNT_BITS'(1);
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_go) begin
                        r_odata  <= {6'(r_fc), 16'(r_status == ST_DONE ? r_be : '0),
                                     16'(r_status == ST_DONE ? r_bs : '0), r_status};
                        r_st     <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_st == S_IDLE) && !r_init;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

`ifndef NO_ASSERTIONS
    a_fc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= MAXC) else $error("free count overflow");
    a_uc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_uc <= MAXC) else $error("used count overflow");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("accepted while busy");
`endif
endmodule

[sv/fpba_cell.sv]
// One table cell: holds a start/end/tag entry and shifts with its neighbors.
`timescale 1ns / 1ps
module fpba_cell
    import fpba_pkg::*;
#(
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF
) (
    input  logic                  i_clk,
    input  t_cmd                  i_cmd,
    input  logic                  i_at_sel,
    input  logic                  i_after_sel,
    input  logic                  i_next_sel,
    input  logic [ADDR_BITS-1:0]  i_load_s,
    input  logic [ADDR_BITS-1:0]  i_load_e,
    input  logic [OWNER_BITS-1:0] i_load_o,
    input  logic [ADDR_BITS-1:0]  i_left_s,
    input  logic [ADDR_BITS-1:0]  i_left_e,
    input  logic [OWNER_BITS-1:0] i_left_o,
    input  logic [ADDR_BITS-1:0]  i_right_s,
    input  logic [ADDR_BITS-1:0]  i_right_e,
    input  logic [OWNER_BITS-1:0] i_right_o,
    output logic [ADDR_BITS-1:0]  o_s,
    output logic [ADDR_BITS-1:0]  o_e,
    output logic [OWNER_BITS-1:0] o_o
);
    logic [ADDR_BITS-1:0]  r_s, n_s, r_e, n_e;
    logic [OWNER_BITS-1:0] r_o, n_o;

    always_comb begin
        n_s = r_s;
        n_e = r_e;
        n_o = r_o;
        case (i_cmd)
            C_INIT: begin
                n_s = i_load_s;
                n_e = i_load_e;
                n_o = i_load_o;
            end
            C_REMOVE: begin
                if (i_at_sel || i_after_sel) begin
                    n_s = i_right_s;
                    n_e = i_right_e;
                    n_o = i_right_o;
                end
            end
            C_INSERT: begin
                if (i_after_sel) begin
                    n_s = i_left_s;
                    n_e = i_left_e;
                    n_o = i_left_o;
                end else if (i_at_sel) begin
                    n_s = i_load_s;
                    n_e = i_load_e;
                    n_o = i_load_o;
                end
            end
            C_SWAP: begin
                if (i_at_sel) begin
                    n_s = i_right_s;
                    n_e = i_right_e;
                    n_o = i_right_o;
                end else if (i_next_sel) begin
                    n_s = i_left_s;
                    n_e = i_left_e;
                    n_o = i_left_o;
                end
            end
            C_WRITE: begin
                if (i_at_sel) begin
                    n_s = i_load_s;
                    n_e = i_load_e;
                    n_o = i_load_o;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        r_e <= n_e;
        r_o <= n_o;
    end

    assign o_s = r_s;
    assign o_e = r_e;
    assign o_o = r_o;
endmodule

[sv/fpba_row.sv]
// Row of table cells with a shared command and a selected position.
`timescale 1ns / 1ps
module fpba_row
    import fpba_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int OWNER_BITS = OWNER_BITS_DEF,
    parameter int IDX_BITS   = $clog2(MAX_BLOCKS)
) (
    input  logic                  i_clk,
    input  t_cmd                  i_cmd,
    input  logic [IDX_BITS-1:0]   i_sel,
    input  logic [ADDR_BITS-1:0]  i_load_s,
    input  logic [ADDR_BITS-1:0]  i_load_e,
    input  logic [OWNER_BITS-1:0] i_load_o,
    input  logic [IDX_BITS-1:0]   i_rd,
    output logic [ADDR_BITS-1:0]  o_rd_s,
    output logic [ADDR_BITS-1:0]  o_rd_e,
    output logic [OWNER_BITS-1:0] o_rd_o,
    output logic [ADDR_BITS-1:0]  o_nx_s,
    output logic [ADDR_BITS-1:0]  o_nx_e
);
    logic [ADDR_BITS-1:0]  w_s [MAX_BLOCKS+1];
    logic [ADDR_BITS-1:0]  w_e [MAX_BLOCKS+1];
    logic [OWNER_BITS-1:0] w_o [MAX_BLOCKS+1];
    logic [IDX_BITS-1:0]   w_nx;

    // Padding past the last cell shifts in zeros.
    assign w_s[MAX_BLOCKS] = '0;
    assign w_e[MAX_BLOCKS] = '0;
    assign w_o[MAX_BLOCKS] = '0;

    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        logic [ADDR_BITS-1:0]  w_ls, w_le;
        logic [OWNER_BITS-1:0] w_lo;
        logic                  w_go;
        if (g == 0) begin : g_first
            assign w_ls = '0;
            assign w_le = '0;
            assign w_lo = '0;
        end else begin : g_rest
            assign w_ls = w_s[g-1];
            assign w_le = w_e[g-1];
            assign w_lo = w_o[g-1];
        end
        // C_INIT loads cell 0 only; other cells hold.
        assign w_go = (i_cmd == C_INIT) && (g != 0);
        fpba_cell #(.ADDR_BITS(ADDR_BITS), .OWNER_BITS(OWNER_BITS)) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_go ? C_HOLD : i_cmd),
            .i_at_sel   (i_sel == IDX_BITS'(g)),
            .i_after_sel(IDX_BITS'(g) > i_sel),
            .i_next_sel (g != 0 && i_sel == IDX_BITS'(g - 1)),
            .i_load_s   (i_load_s),
            .i_load_e   (i_load_e),
            .i_load_o   (i_load_o),
            .i_left_s   (w_ls),
            .i_left_e   (w_le),
            .i_left_o   (w_lo),
            .i_right_s  (w_s[g+1]),
            .i_right_e  (w_e[g+1]),
            .i_right_o  (w_o[g+1]),
            .o_s        (w_s[g]),
            .o_e        (w_e[g]),
            .o_o        (w_o[g])
        );
    end

    assign w_nx   = i_rd + IDX_BITS'(1);
    assign o_rd_s = w_s[i_rd];
    assign o_rd_e = w_e[i_rd];
    assign o_rd_o = w_o[i_rd];
    assign o_nx_s = w_s[w_nx];
    assign o_nx_e = w_e[w_nx];
endmodule
